// ===== hw/rtl/moving_tanh_shock_velocity_unit_macros.svh =====
// Assertion macros used by the shock velocity unit checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MOVING_TANH_SHOCK_VELOCITY_UNIT_MACROS_SVH
`define MOVING_TANH_SHOCK_VELOCITY_UNIT_MACROS_SVH

// general property, quiet while reset is held
`define MTSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// a stalled request keeps its valid and its payload
`define MTSV_ASSERT_HOLD(lbl, vld, rdy, data, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

// ===== hw/rtl/mtsv_pkg.sv =====
// Constants, types and elaboration-time tables of the shock velocity unit.
// No dependencies; imported by the top level and its checker.
package mtsv_pkg;

  localparam int unsigned FRAC_BITS        = 16;
  // power of two, 32 to 4096
  localparam int unsigned TANH_TABLE_DEPTH = 256;
  localparam int unsigned TBL_BITS         = $clog2(TANH_TABLE_DEPTH);
  localparam int unsigned SERIES_TERMS     = 16;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CFG_DATA_W       = 32;

  localparam logic [63:0] ONE31   = 64'h0000_0000_8000_0000;
  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHOCK_SPEED      = 3'd0,
    CFG_UPSTREAM_SPEED   = 3'd1,
    CFG_DOWNSTREAM_SPEED = 3'd2,
    CFG_SHOCK_THICKNESS  = 3'd3,
    CFG_START_POSITION   = 3'd4,
    CFG_START_TIME       = 3'd5
  } cfg_idx_e;

  typedef logic [31:0] rom_t [TANH_TABLE_DEPTH];

  // exp(-v) for v below 1.0 in Q1.31, truncated alternating series
  function automatic logic [31:0] exp_series_f(logic [63:0] v);
    logic [63:0] term;
    longint      acc;
    term = ONE31;
    acc  = longint'(ONE31);
    for (int Kd = 1; Kd <= int'(SERIES_TERMS); Kd++) begin
      term = ((term * v) >> 31) / 64'(Kd);
      if (Kd[0]) acc = acc - longint'(term);
      else       acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE31)) acc = longint'(ONE31);
    return 32'(acc);
  endfunction

  function automatic rom_t build_exp_rom();
    rom_t rom;
    for (int j = 0; j < int'(TANH_TABLE_DEPTH); j++) begin
      rom[j] = exp_series_f(64'(j) << (31 - TBL_BITS));
    end
    return rom;
  endfunction

  localparam rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== hw/rtl/moving_tanh_shock_velocity_unit.sv =====
// Velocity and divergence of a planar tanh-smoothed shock, fully pipelined.
// Depends on mtsv_pkg.
//
// The unit takes one (position_x, time_now) request per clock unless a result
// waits, and returns one result per request, in order. Its depth comes from
// three restoring dividers that resolve one quotient bit per stage (z/width,
// the tanh quotient and the divergence scale) and the sixteen series terms of
// exp(), three stages each. Every stage moves together: the pipeline holds
// while a finished result waits on m_axis_tready_i and s_axis_tready_o is low
// only then. shock_thickness 0 acts as 1 LSB. The user writes configuration
// through the cfg port while no request is in flight, not enforced by the unit.
module moving_tanh_shock_velocity_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mtsv_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mtsv_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [63:0]                        s_axis_tdata_i,  // position_x, time_now
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [63:0]                        m_axis_tdata_o,  // velocity_x, velocity_gradient
  output logic [0:0]                         m_axis_tuser_o   // saturated
);
  import mtsv_pkg::*;

  localparam int unsigned RW    = 31 - TBL_BITS;
  localparam int unsigned D1N   = 31;
  localparam int unsigned SERN  = 3 * SERIES_TERMS;
  localparam int unsigned SQN   = 4;
  localparam int unsigned D2N   = 32;
  localparam int unsigned D3N   = 32;
  localparam int unsigned DEN3W = 63 - FRAC_BITS;
  localparam int unsigned NSTG  = 4 + D1N + 1 + SERN + 1 + (SQN + 1) + (D2N + 1) + 3
                                  + (D3N + 1) + 1;

  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] dv;
    logic [30:0] quo;
    logic        zneg;
    logic        neg;
    logic        big;
  } d1_t;

  typedef struct packed {
    logic [31:0]        term;
    logic [63:0]        prod;
    logic [31:0]        t1;
    logic [31:0]        est;
    logic signed [33:0] acc;
    logic [RW-1:0]      r;
    logic [TBL_BITS-1:0] j;
    logic               zneg;
    logic               neg;
    logic               big;
  } ser_t;

  typedef struct packed {
    logic [31:0] e;
    logic [31:0] t;
    logic        zneg;
    logic        neg;
    logic        big;
  } ex_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [32:0] den;
    logic [31:0] dv;
    logic [31:0] quo;
    logic        zneg;
    logic        neg;
    logic        big;
  } d2_t;

  typedef struct packed {
    logic [DEN3W:0] rem;
    logic [31:0]    dv;
    logic [31:0]    quo;
    logic           ovf;
    logic [31:0]    vel;
    logic           clipv;
    logic           neg;
  } d3_t;

  // configuration
  logic signed [31:0] vs_q, up_q, dn_q, x0_q, t0_q;
  logic [30:0]        w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= '0;
      up_q <= '0;
      dn_q <= '0;
      w_q  <= 31'(64'd1 << FRAC_BITS);
      x0_q <= '0;
      t0_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SHOCK_SPEED:      vs_q <= cfg_data_i;
        CFG_UPSTREAM_SPEED:   up_q <= cfg_data_i;
        CFG_DOWNSTREAM_SPEED: dn_q <= cfg_data_i;
        CFG_SHOCK_THICKNESS:  w_q  <= cfg_data_i[30:0];
        CFG_START_POSITION:   x0_q <= cfg_data_i;
        CFG_START_TIME:       t0_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [30:0]        w_eff;
  logic signed [32:0] sum_s, dif_s;
  logic [32:0]        dif_mag;
  logic [31:0]        vs_mag;

  assign w_eff   = (w_q == '0) ? 31'd1 : w_q;
  assign sum_s   = 33'(up_q) + 33'(dn_q);
  assign dif_s   = 33'(up_q) - 33'(dn_q);
  assign dif_mag = dif_s[32] ? 33'(-dif_s) : 33'(dif_s);
  assign vs_mag  = vs_q[31] ? 32'(-vs_q) : 32'(vs_q);

  // global advance: hold everything while a result waits
  logic adv;
  logic [NSTG-1:0] vld_q;

  assign adv             = !vld_q[NSTG-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid_i};
    end
  end

  // stage 1: time since start
  logic signed [31:0] x1_q, x2_q;
  logic signed [32:0] dt1_d, dt1_q;
  logic               neg1_q, neg2_q, neg3_q;

  assign dt1_d = 33'(signed'(s_axis_tdata_i[63:32])) - 33'(t0_q);

  // stage 2: front displacement product
  logic [32:0] dt_mag;
  logic [63:0] pm2_d, pm2_q;
  logic        pneg2_q;

  assign dt_mag = dt1_q[32] ? 33'(-dt1_q) : 33'(dt1_q);
  assign pm2_d  = 64'(vs_mag) * 64'(dt_mag);

  // stage 3: distance to the front
  logic [63:0]        rs;
  logic signed [63:0] rs_s, z3;
  logic [63:0]        az3_d, az3_q;
  logic               zneg3_q;

  assign rs    = (pm2_q + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign rs_s  = pneg2_q ? -signed'(rs) : signed'(rs);
  assign z3    = 64'(x2_q) - 64'(x0_q) - rs_s;
  assign az3_d = z3[63] ? 64'(-z3) : 64'(z3);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q    <= signed'(s_axis_tdata_i[31:0]);
      dt1_q   <= dt1_d;
      neg1_q  <= dt1_d[32];
      x2_q    <= x1_q;
      pm2_q   <= pm2_d;
      pneg2_q <= vs_q[31] ^ dt1_q[32];
      neg2_q  <= neg1_q;
      az3_q   <= az3_d;
      zneg3_q <= z3[63];
      neg3_q  <= neg2_q;
    end
  end

  // stage 4 and divider 1: y = |z| * 2^28 / w, |u|/8 in Q1.31
  d1_t d1_d [D1N+1];
  d1_t d1_q [D1N+1];

  always_comb begin
    d1_d[0].big  = az3_q >= {30'd0, w_eff, 3'b000};
    d1_d[0].rem  = {1'b0, az3_q[33:3]};
    d1_d[0].dv   = {az3_q[2:0], 28'd0};
    d1_d[0].quo  = '0;
    d1_d[0].zneg = zneg3_q;
    d1_d[0].neg  = neg3_q;
  end

  for (genvar i = 1; i <= D1N; i++) begin : g_div1
    always_comb begin : step
      logic [31:0] rem_sh;
      logic        ge;
      rem_sh   = {d1_q[i-1].rem[30:0], d1_q[i-1].dv[30]};
      ge       = rem_sh >= {1'b0, w_eff};
      d1_d[i]      = d1_q[i-1];
      d1_d[i].rem  = ge ? rem_sh - {1'b0, w_eff} : rem_sh;
      d1_d[i].dv   = {d1_q[i-1].dv[29:0], 1'b0};
      d1_d[i].quo  = {d1_q[i-1].quo[29:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i <= int'(D1N); i++) d1_q[i] <= d1_d[i];
    end
  end

  // exp(-r) series for the residue above the table point
  ser_t ser_d [SERN+1];
  ser_t ser_q [SERN+1];

  always_comb begin
    ser_d[0].term = 32'(ONE31);
    ser_d[0].prod = '0;
    ser_d[0].t1   = '0;
    ser_d[0].est  = '0;
    ser_d[0].acc  = 34'(ONE31);
    ser_d[0].r    = d1_q[D1N].quo[RW-1:0];
    ser_d[0].j    = d1_q[D1N].quo[30:RW];
    ser_d[0].zneg = d1_q[D1N].zneg;
    ser_d[0].neg  = d1_q[D1N].neg;
    ser_d[0].big  = d1_q[D1N].big;
  end

  for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_term
    localparam int unsigned   K   = k;
    localparam logic [32:0]   Rcp = 33'((64'd1 << 32) / K);
    localparam int unsigned   SA  = 3 * k - 2;

    always_comb begin
      ser_d[SA]      = ser_q[SA-1];
      ser_d[SA].prod = 64'(ser_q[SA-1].term) * 64'(ser_q[SA-1].r);
    end

    // divide by k through its reciprocal, low by at most one
    always_comb begin
      ser_d[SA+1]     = ser_q[SA];
      ser_d[SA+1].t1  = 32'(ser_q[SA].prod >> 31);
      ser_d[SA+1].est = 32'((64'(32'(ser_q[SA].prod >> 31)) * 64'(Rcp)) >> 32);
    end

    always_comb begin : fix
      logic [31:0] rmd;
      logic [31:0] tnew;
      rmd  = ser_q[SA+1].t1 - 32'(ser_q[SA+1].est * 32'(K));
      tnew = ser_q[SA+1].est + 32'(rmd >= 32'(K));
      ser_d[SA+2]      = ser_q[SA+1];
      ser_d[SA+2].term = tnew;
      ser_d[SA+2].acc  = K[0] ? ser_q[SA+1].acc - 34'(tnew) : ser_q[SA+1].acc + 34'(tnew);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i <= int'(SERN); i++) ser_q[i] <= ser_d[i];
    end
  end

  // table point times residue, then four squarings give exp(-2|u|)
  ex_t ex_d, ex_q;
  ex_t sq_d [SQN+1];
  ex_t sq_q [SQN+1];

  always_comb begin
    ex_d.zneg = ser_q[SERN].zneg;
    ex_d.neg  = ser_q[SERN].neg;
    ex_d.big  = ser_q[SERN].big;
    ex_d.t    = EXP_ROM[ser_q[SERN].j];
    if (ser_q[SERN].acc < 0) begin
      ex_d.e = '0;
    end else if (ser_q[SERN].acc > 34'(ONE31)) begin
      ex_d.e = 32'(ONE31);
    end else begin
      ex_d.e = 32'(ser_q[SERN].acc);
    end
  end

  always_comb begin
    sq_d[0]   = ex_q;
    sq_d[0].e = 32'((64'(ex_q.t) * 64'(ex_q.e) + (ONE31 >> 1)) >> 31);
  end

  for (genvar i = 1; i <= SQN; i++) begin : g_sq
    always_comb begin
      sq_d[i]   = sq_q[i-1];
      sq_d[i].e = 32'((64'(sq_q[i-1].e) * 64'(sq_q[i-1].e) + (ONE31 >> 1)) >> 31);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ex_q <= ex_d;
      for (int i = 0; i <= int'(SQN); i++) sq_q[i] <= sq_d[i];
    end
  end

  // divider 2: tanh = (1 - e) / (1 + e), rounded
  d2_t d2_d [D2N+1];
  d2_t d2_q [D2N+1];

  always_comb begin : prep2
    logic [63:0] num2;
    logic [32:0] den2;
    logic [63:0] n2;
    num2 = (ONE31 - 64'(sq_q[SQN].e)) << 31;
    den2 = 33'(ONE31) + 33'(sq_q[SQN].e);
    n2   = num2 + 64'(den2 >> 1);
    d2_d[0].rem  = 34'(n2 >> 32);
    d2_d[0].den  = den2;
    d2_d[0].dv   = n2[31:0];
    d2_d[0].quo  = '0;
    d2_d[0].zneg = sq_q[SQN].zneg;
    d2_d[0].neg  = sq_q[SQN].neg;
    d2_d[0].big  = sq_q[SQN].big;
  end

  for (genvar i = 1; i <= D2N; i++) begin : g_div2
    always_comb begin : step
      logic [33:0] rem_sh;
      logic        ge;
      rem_sh = {d2_q[i-1].rem[32:0], d2_q[i-1].dv[31]};
      ge     = rem_sh >= 34'(d2_q[i-1].den);
      d2_d[i]     = d2_q[i-1];
      d2_d[i].rem = ge ? rem_sh - 34'(d2_q[i-1].den) : rem_sh;
      d2_d[i].dv  = {d2_q[i-1].dv[30:0], 1'b0};
      d2_d[i].quo = {d2_q[i-1].quo[30:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i <= int'(D2N); i++) d2_q[i] <= d2_d[i];
    end
  end

  // post stages: velocity and divergence numerator
  logic [31:0]        th_mag;
  logic [63:0]        md_q, ts_q;
  logic               zneg_p1_q, neg_p1_q;
  logic [32:0]        rdt;
  logic signed [34:0] dterm, v_d, v_q;
  logic [31:0]        q_d, q_q;
  logic               neg_p2_q;
  logic [34:0]        vmag, vrnd;
  logic signed [34:0] vsig;
  logic [31:0]        vel_d, vel_q;
  logic               clipv_d, clipv_q, neg_p3_q;
  logic [63:0]        numg_q;

  assign th_mag = d2_q[D2N].big ? 32'(ONE31) : d2_q[D2N].quo;
  assign rdt    = 33'((md_q + (ONE31 >> 1)) >> 31);
  assign dterm  = (dif_s[32] ^ zneg_p1_q) ? -signed'(35'(rdt)) : signed'(35'(rdt));
  assign v_d    = 35'(sum_s) - dterm;
  assign q_d    = 32'(ONE31) - 32'((ts_q + (ONE31 >> 1)) >> 31);
  assign vmag   = v_q[34] ? 35'(-v_q) : 35'(v_q);
  assign vrnd   = (vmag + 35'd1) >> 1;
  assign vsig   = v_q[34] ? -signed'(vrnd) : signed'(vrnd);

  always_comb begin
    clipv_d = 1'b0;
    if (vsig > 35'sd2147483647) begin
      vel_d   = SAT_MAX;
      clipv_d = 1'b1;
    end else if (vsig < -35'sd2147483648) begin
      vel_d   = SAT_MIN;
      clipv_d = 1'b1;
    end else begin
      vel_d = vsig[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      md_q      <= 64'(dif_mag) * 64'(th_mag);
      ts_q      <= 64'(th_mag) * 64'(th_mag);
      zneg_p1_q <= d2_q[D2N].zneg;
      neg_p1_q  <= d2_q[D2N].neg;
      v_q       <= v_d;
      q_q       <= q_d;
      neg_p2_q  <= neg_p1_q;
      vel_q     <= vel_d;
      clipv_q   <= clipv_d;
      numg_q    <= 64'(dif_mag) * 64'(q_q);
      neg_p3_q  <= neg_p2_q;
    end
  end

  // divider 3: |D| * q / (w * 2^(32-F)), rounded, with overflow flag
  d3_t d3_d [D3N+1];
  d3_t d3_q [D3N+1];
  logic [DEN3W-1:0] den3;

  assign den3 = DEN3W'(w_eff) << (32 - FRAC_BITS);

  always_comb begin : prep3
    logic [63:0] n3;
    n3 = numg_q + 64'(den3 >> 1);
    d3_d[0].ovf   = (n3 >> 32) >= 64'(den3);
    d3_d[0].rem   = (DEN3W + 1)'(n3 >> 32);
    d3_d[0].dv    = n3[31:0];
    d3_d[0].quo   = '0;
    d3_d[0].vel   = vel_q;
    d3_d[0].clipv = clipv_q;
    d3_d[0].neg   = neg_p3_q;
  end

  for (genvar i = 1; i <= D3N; i++) begin : g_div3
    always_comb begin : step
      logic [DEN3W:0] rem_sh;
      logic           ge;
      rem_sh = {d3_q[i-1].rem[DEN3W-1:0], d3_q[i-1].dv[31]};
      ge     = rem_sh >= (DEN3W + 1)'(den3);
      d3_d[i]     = d3_q[i-1];
      d3_d[i].rem = ge ? rem_sh - (DEN3W + 1)'(den3) : rem_sh;
      d3_d[i].dv  = {d3_q[i-1].dv[30:0], 1'b0};
      d3_d[i].quo = {d3_q[i-1].quo[30:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i <= int'(D3N); i++) d3_q[i] <= d3_d[i];
    end
  end

  // output register: sign, clip, zero before start
  logic [31:0] grad_d, grad_q, vout_q, g_fin;
  logic        sat_d, sat_q, clipg;
  logic        g_ovf;

  assign g_fin = d3_q[D3N].quo;
  assign g_ovf = d3_q[D3N].ovf;

  always_comb begin
    clipg  = 1'b0;
    grad_d = '0;
    if (!d3_q[D3N].neg) begin
      if (dif_s > 0) begin
        clipg  = g_ovf || (g_fin > SAT_MIN);
        grad_d = clipg ? SAT_MIN : 32'(-g_fin);
      end else begin
        clipg  = g_ovf || (g_fin > SAT_MAX);
        grad_d = clipg ? SAT_MAX : g_fin;
      end
    end
    sat_d = clipg || d3_q[D3N].clipv;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vout_q <= d3_q[D3N].vel;
      grad_q <= grad_d;
      sat_q  <= sat_d;
    end
  end

  assign m_axis_tdata_o = {grad_q, vout_q};
  assign m_axis_tuser_o = sat_q;

endmodule

// ===== hw/rtl/mtsv_checker.sv =====
// Port-level checks for the shock velocity unit, bound to its top level.
// Depends on mtsv_pkg and moving_tanh_shock_velocity_unit_macros.svh.
`include "moving_tanh_shock_velocity_unit_macros.svh"

module mtsv_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [63:0]                     m_axis_tdata_o,  // velocity_x, velocity_gradient
  input logic [0:0]                      m_axis_tuser_o   // saturated
);
  import mtsv_pkg::*;

  // a result not taken stays on the bus unchanged
  `MTSV_ASSERT_HOLD(a_out_hold, m_axis_tvalid_o, m_axis_tready_i, m_axis_tdata_o, "result dropped while stalled")

  // requests are refused only while a result waits
  `MTSV_ASSERT(a_ready_stall, !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i), "input held without a waiting result")

  // a drained output never blocks the input side
  `MTSV_ASSERT(a_ready_free, (m_axis_tvalid_o && m_axis_tready_i) |-> s_axis_tready_o, "input not ready while result taken")

  // saturation must show in one of the two outputs
  `MTSV_ASSERT(a_sat_flag, (m_axis_tvalid_o && m_axis_tuser_o[0] && m_axis_tdata_o[31:0] != SAT_MAX && m_axis_tdata_o[31:0] != SAT_MIN) |-> (m_axis_tdata_o[63:32] == SAT_MAX || m_axis_tdata_o[63:32] == SAT_MIN), "saturated flag without a clipped output")

endmodule

bind moving_tanh_shock_velocity_unit mtsv_checker u_mtsv_checker (.*);

// ===== tb/moving_tanh_shock_velocity_unit_tb.sv =====
// Self-checking testbench of moving_tanh_shock_velocity_unit: streams position/time
// requests, predicts velocity, divergence and clip flag, and checks each result in order.
// Depends on mtsv_pkg and the unit's RTL.
module moving_tanh_shock_velocity_unit_tb;
  import mtsv_pkg::*;

  localparam logic [63:0]  HALF31 = 64'h4000_0000;
  localparam logic [2:0]   CFG_SPARE_LO = 3'd6;
  localparam logic [2:0]   CFG_SPARE_HI = 3'd7;
  localparam longint       INT_MAX = 64'sh7FFF_FFFF;
  localparam longint       INT_MIN = -64'sh8000_0000;
  localparam int           CYCLE_LIMIT = 1_000_000;
  localparam int           DRAIN_CYCLES = 200;

  typedef struct {
    logic [31:0] velocity;
    logic [31:0] gradient;
    logic        clipped;
  } shock_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;

  moving_tanh_shock_velocity_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  always #5 clk = ~clk;

  // shadow of the configuration
  longint      front_speed = 0, up_speed = 0, down_speed = 0;
  longint      front_x0 = 0, front_t0 = 0;
  logic [63:0] thickness = 64'd65536;

  logic [31:0]   exp_table [TANH_TABLE_DEPTH];
  shock_result_t pending_results [$];
  int            src_idle_pct = 0, snk_idle_pct = 0;
  int            fail_count = 0;
  int            cycles = 0;

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // a*b / 2^s, rounded to nearest with ties away from zero
  function automatic longint scale_round(longint a, longint b, int s);
    logic [127:0] m;
    m = 128'(magnitude(a)) * 128'(magnitude(b));
    m = (m + (128'd1 << (s - 1))) >> s;
    return ((a < 0) != (b < 0)) ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint clip32(longint v, ref logic clipped);
    if (v > INT_MAX) begin clipped = 1'b1; return INT_MAX; end
    if (v < INT_MIN) begin clipped = 1'b1; return INT_MIN; end
    return v;
  endfunction

  function automatic logic [63:0] exp_neg_q31(logic [63:0] v);
    logic [63:0] term;
    longint      acc;
    term = ONE31;
    acc = longint'(ONE31);
    for (int k = 1; k <= 16; k++) begin
      term = ((term * v) >> 31) / 64'(k);
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE31)) acc = longint'(ONE31);
    return 64'(acc);
  endfunction

  function automatic logic [63:0] table_point(int j);
    return (64'(j) << 31) / 64'(TANH_TABLE_DEPTH);
  endfunction

  function automatic longint tanh_q31(longint z, logic [63:0] w);
    logic [63:0] az, y, j, e, num, den;
    az = magnitude(z);
    if (az >= 8 * w) return z < 0 ? -longint'(ONE31) : longint'(ONE31);
    y = (az << 28) / w;
    j = (y * 64'(TANH_TABLE_DEPTH)) >> 31;
    if (j >= 64'(TANH_TABLE_DEPTH)) j = 64'(TANH_TABLE_DEPTH - 1);
    e = (64'(exp_table[j]) * exp_neg_q31(y - table_point(int'(j))) + HALF31) >> 31;
    for (int i = 0; i < 4; i++) e = (e * e + HALF31) >> 31;
    num = (ONE31 - e) << 31;
    den = ONE31 + e;
    return z < 0 ? -longint'((num + den / 2) / den) : longint'((num + den / 2) / den);
  endfunction

  function automatic longint front_position(longint t);
    return front_x0 + scale_round(front_speed, t - front_t0, FRAC_BITS);
  endfunction

  function automatic shock_result_t shock_response(logic [31:0] x_raw, logic [31:0] t_raw);
    shock_result_t r;
    logic [63:0]   w, thm, q, num, den, g;
    longint        t, th, s_sum, d_diff, vel, grad;
    logic          clipped;
    clipped = 1'b0;
    w = thickness == 0 ? 64'd1 : thickness;
    t = sx32(t_raw);
    th = tanh_q31(sx32(x_raw) - front_position(t), w);
    s_sum = up_speed + down_speed;
    d_diff = up_speed - down_speed;
    vel = clip32(scale_round(s_sum - scale_round(d_diff, th, 31), 1, 1), clipped);
    grad = 0;
    if (t >= front_t0) begin
      thm = magnitude(th);
      q = ONE31 - ((thm * thm + HALF31) >> 31);
      num = magnitude(d_diff) * q;
      den = w << (32 - FRAC_BITS);
      g = (num + den / 2) / den;
      grad = clip32(d_diff > 0 ? -longint'(g) : longint'(g), clipped);
    end
    r.velocity = vel[31:0];
    r.gradient = grad[31:0];
    r.clipped = clipped;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    case (idx)
      CFG_SHOCK_SPEED:      front_speed = sx32(val);
      CFG_UPSTREAM_SPEED:   up_speed = sx32(val);
      CFG_DOWNSTREAM_SPEED: down_speed = sx32(val);
      CFG_SHOCK_THICKNESS:  thickness = 64'(val[30:0]);
      CFG_START_POSITION:   front_x0 = sx32(val);
      CFG_START_TIME:       front_t0 = sx32(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] vs, logic [31:0] up, logic [31:0] down,
                           logic [31:0] w, logic [31:0] x0, logic [31:0] t0);
    wait_drained();
    write_reg(CFG_SHOCK_SPEED, vs);
    write_reg(CFG_UPSTREAM_SPEED, up);
    write_reg(CFG_DOWNSTREAM_SPEED, down);
    write_reg(CFG_SHOCK_THICKNESS, w);
    write_reg(CFG_START_POSITION, x0);
    write_reg(CFG_START_TIME, t0);
  endtask

  // drive one request, record its expected result once accepted
  task automatic send_query(logic [31:0] x, logic [31:0] t);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {t, x};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(shock_response(x, t));
  endtask

  task automatic end_burst();
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  always @(negedge clk) m_tready = ($urandom_range(0, 99) >= snk_idle_pct);

  always @(posedge clk) begin
    shock_result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[31:0] !== want.velocity) begin
          $error("velocity_x expected %h got %h", want.velocity, m_tdata[31:0]);
          fail_count++;
        end
        if (m_tdata[63:32] !== want.gradient) begin
          $error("velocity_gradient expected %h got %h", want.gradient, m_tdata[63:32]);
          fail_count++;
        end
        if (m_tuser[0] !== want.clipped) begin
          $error("saturated expected %b got %b", want.clipped, m_tuser[0]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[moving_tanh_shock_velocity_unit] ERROR");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_query(32'h0, 32'h0);
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
    send_query(32'h0001_0000, 32'hFFFF_FFFF);
    end_burst();
  endtask

  task automatic test_unknown_index();
    wait_drained();
    write_reg(CFG_UPSTREAM_SPEED, 32'h0004_0000);
    write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_HI, 32'h1234_5678);
    send_query(32'h0000_8000, 32'h0000_0000);
    send_query(32'hFFFF_8000, 32'h0001_0000);
    end_burst();
  endtask

  task automatic test_extremes();
    // speeds at opposite extremes, zero thickness treated as one LSB
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h8000_0000, 32'h8000_0000);
    send_query(32'h0, 32'h0);
    end_burst();
    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF);
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    send_query(32'h8000_0000, 32'h7FFF_FFFF);
    send_query(32'h0, 32'h0);
    end_burst();
    configure(32'h0, 32'h8000_0000, 32'h8000_0000, 32'h1, 32'h0, 32'h0);
    send_query(32'h0, 32'h0);
    send_query(32'h1, 32'h0);
    end_burst();
  endtask

  task automatic test_before_start();
    configure(32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000,
              32'h0005_0000);
    send_query(32'h0001_0000, 32'h0004_FFFF);
    send_query(32'h0001_0000, 32'h0005_0000);
    send_query(32'h0001_4000, 32'h0000_0000);
    send_query(32'h0008_0000, 32'h0008_0000);
    send_query(32'hFFF0_0000, 32'h0005_0001);
    end_burst();
  endtask

  function automatic logic [31:0] random_speed();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return 32'($signed(32'($urandom_range(0, 32'h001F_FFFF))) - 32'sh0010_0000);
  endfunction

  task automatic random_configuration();
    logic [31:0] w;
    case ($urandom_range(0, 3))
      0: w = $urandom_range(0, 255);
      1: w = $urandom_range(32'h0000_4000, 32'h0004_0000);
      2: w = $urandom >> $urandom_range(1, 31);
      default: w = $urandom & 32'h7FFF_FFFF;
    endcase
    configure(random_speed(), random_speed(), random_speed(), w,
              $urandom_range(0, 1) ? $urandom : random_speed(),
              $urandom_range(0, 1) ? $urandom : random_speed());
  endtask

  task automatic test_random_stream(int src_pct, int snk_pct, int count);
    longint      t, x, w;
    logic [31:0] xr, tr;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        end_burst();
        random_configuration();
      end
      if ($urandom_range(0, 9) < 7) begin
        // aim at the smoothed front, from either side
        tr = ($urandom_range(0, 3) == 0) ? $urandom : 32'(front_t0 +
             longint'($urandom_range(0, 32'h0002_0000)) - 64'sh0001_0000);
        t = sx32(tr);
        w = (thickness == 0) ? 1 : longint'(thickness);
        x = front_position(t) + (longint'($urandom) % (10 * w + 1)) - 5 * w;
        xr = (x > INT_MAX || x < INT_MIN) ? $urandom : x[31:0];
      end else begin
        xr = $urandom;
        tr = $urandom;
      end
      send_query(xr, tr);
    end
    end_burst();
  endtask

  initial begin
    for (int j = 0; j < TANH_TABLE_DEPTH; j++) exp_table[j] = 32'(exp_neg_q31(table_point(j)));
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_unknown_index();
    test_extremes();
    test_before_start();
    test_random_stream(7, 57, 600);
    test_random_stream(57, 7, 600);
    test_random_stream(0, 0, 600);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[moving_tanh_shock_velocity_unit] OK");
    end else begin
      $display("[moving_tanh_shock_velocity_unit] ERROR");
    end
    $finish;
  end

endmodule
